FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; take it in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pccs_pkg.sv
// Types and constants of the phantom credit congestion sensor.
// No dependencies; used by every module of the block.
package pccs_pkg;

    localparam int VCOEFF_W  = 16;
    localparam int STATUS_W  = 17;
    localparam int DIVW      = 23;
    localparam logic [VCOEFF_W-1:0] VCOEFF_RESET = 16'd256;
    localparam logic [STATUS_W-1:0] STATUS_ONE   = 17'h10000;

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_RETURN  = 3'd1;
    localparam logic [2:0] CMD_CONSUME = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [1:0] ERR_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  port;
        logic [1:0]  vc;
        logic [6:0]  credits;
        logic [11:0] window_length;
    } in_item_t;

    typedef struct packed {
        logic [16:0] status;
        logic [1:0]  error;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic apply;
        logic tick_adv;
        logic rd_head;
        logic retire;
        logic scan_next;
        logic q_mul;
        logic q_num;
        logic div_step;
        logic q_fin;
    } pccs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] command;
        logic       scan_nonempty;
        logic       scan_last;
        logic       head_expired;
        logic       q_trivial;
        logic       div_last;
    } pccs_sts_t;

endpackage

FILE: rtl/pccs_div.sv
// Restoring divider, one quotient bit per step, for the query fraction.
// Depends on pccs_pkg for the dividend width.
module pccs_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      step,
    input  logic [pccs_pkg::DIVW-1:0] dividend,
    input  logic [6:0]                divisor,
    output logic [pccs_pkg::DIVW-1:0] quotient,
    output logic                      last
);

    localparam int CW = $clog2(pccs_pkg::DIVW);

    logic [pccs_pkg::DIVW-1:0] q_reg;
    logic [6:0]                rem_reg;
    logic [6:0]                dvs_reg;
    logic [CW-1:0]             cnt_reg;
    logic [7:0]                shifted;
    logic                      ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, q_reg[pccs_pkg::DIVW-1]};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    // Load operands, then shift one quotient bit in per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= ge ? 7'(shifted - {1'b0, dvs_reg}) : shifted[6:0];
            q_reg   <= {q_reg[pccs_pkg::DIVW-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign last     = (cnt_reg == CW'(pccs_pkg::DIVW - 1));

endmodule

FILE: rtl/pccs_datapath.sv
// Datapath: channel state, phantom expiry memory, query arithmetic.
// Depends on pccs_pkg and pccs_div.
module pccs_datapath #(
    parameter int PORTS         = 8,
    parameter int VCS           = 4,
    parameter int PHANTOM_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pccs_pkg::in_item_t    item,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_data,
    input  pccs_pkg::pccs_cmd_t   cmd,
    output pccs_pkg::pccs_sts_t   sts,
    output pccs_pkg::out_item_t   result
);

    localparam int NCH  = PORTS * VCS;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PTW  = $clog2(PHANTOM_DEPTH);
    localparam int PCW  = $clog2(PHANTOM_DEPTH + 1);
    localparam int MEMD = NCH * PHANTOM_DEPTH;
    localparam int AW   = $clog2(MEMD);
    localparam int PW   = PCW + 16;
    localparam int NW   = PCW + 17;

    pccs_pkg::in_item_t  item_reg;
    pccs_pkg::out_item_t res_reg;
    logic [15:0]         coeff_reg;
    logic [15:0]         now_reg;
    logic                scanning_reg;
    logic [CHW-1:0]      scan_ch_reg;

    logic [6:0]     max_reg  [NCH];
    logic [6:0]     cnt_reg  [NCH];
    logic [11:0]    win_reg  [NCH];
    logic [PCW-1:0] pcnt_reg [NCH];
    logic [PTW-1:0] head_reg [NCH];
    logic [PTW-1:0] tail_reg [NCH];

    logic [15:0]    mem [MEMD];
    logic [15:0]    rd_data_reg;

    logic [6:0]     diff_reg;
    logic [6:0]     maxq_reg;
    logic [PW-1:0]  prod_reg;

    logic [31:0]    ch_full;
    logic           ch_ok;
    logic [CHW-1:0] item_ch;
    logic [CHW-1:0] act_ch;
    logic [6:0]     max_r;
    logic [6:0]     cnt_r;
    logic [11:0]    win_r;
    logic [PCW-1:0] pcnt_r;
    logic [PTW-1:0] head_r;
    logic [PTW-1:0] tail_r;
    logic           pfull;
    logic           add_entry;
    logic [1:0]     apply_err;
    logic [15:0]    age;
    logic [NW-1:0]  num;
    logic           trivial;
    logic [pccs_pkg::DIVW-1:0] quot;
    logic           div_last;

    function automatic logic [PTW-1:0] next_slot(input logic [PTW-1:0] p);
        next_slot = (p == PTW'(PHANTOM_DEPTH - 1)) ? '0 : PTW'(p + 1'b1);
    endfunction

    function automatic logic [AW-1:0] mem_addr(input logic [CHW-1:0] c,
                                               input logic [PTW-1:0] s);
        logic [31:0] a;
        a = 32'(c) * 32'(PHANTOM_DEPTH) + 32'(s);
        mem_addr = a[AW-1:0];
    endfunction

    // Decode the addressed channel; scanning uses its own index
    always_comb
    begin
        ch_full = 32'(item_reg.port) * 32'(VCS) + 32'(item_reg.vc);
        ch_ok   = (32'(item_reg.port) < 32'(PORTS)) && (32'(item_reg.vc) < 32'(VCS));
        item_ch = ch_full[CHW-1:0];
        act_ch  = scanning_reg ? scan_ch_reg : item_ch;
        max_r   = max_reg[act_ch];
        cnt_r   = cnt_reg[act_ch];
        win_r   = win_reg[act_ch];
        pcnt_r  = pcnt_reg[act_ch];
        head_r  = head_reg[act_ch];
        tail_r  = tail_reg[act_ch];
        pfull   = (32'(pcnt_r) >= 32'(PHANTOM_DEPTH));
    end

    // Error of a simple command and whether a consume adds an entry
    always_comb
    begin
        apply_err = pccs_pkg::ERR_OK;
        add_entry = 1'b0;
        if (ch_ok)
        begin
            case (item_reg.command)
                pccs_pkg::CMD_RETURN:
                begin
                    if (cnt_r >= max_r)
                    begin
                        apply_err = pccs_pkg::ERR_OVERFLOW;
                    end
                end
                pccs_pkg::CMD_CONSUME:
                begin
                    if (cnt_r == 7'd0)
                    begin
                        apply_err = pccs_pkg::ERR_UNDERFLOW;
                    end
                    else if (pfull)
                    begin
                        apply_err = pccs_pkg::ERR_FULL;
                    end
                    else
                    begin
                        add_entry = 1'b1;
                    end
                end
                default:
                begin
                    apply_err = pccs_pkg::ERR_OK;
                end
            endcase
        end
    end

    // Query numerator in Q8.8 and the cases that give zero
    always_comb
    begin
        age     = now_reg - rd_data_reg;
        num     = {{(NW-15){1'b0}}, diff_reg, 8'h00} - {1'b0, prod_reg};
        trivial = !ch_ok || (maxq_reg == 7'd0) || num[NW-1] || (num == '0);
    end

    // Hold the item, coefficient, time, scan state, result and query operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg    <= pccs_pkg::VCOEFF_RESET;
            now_reg      <= '0;
            scanning_reg <= 1'b0;
            scan_ch_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                coeff_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                scanning_reg <= 1'b0;
            end
            if (cmd.tick_adv)
            begin
                now_reg      <= now_reg + 16'd1;
                scanning_reg <= 1'b1;
                scan_ch_reg  <= '0;
            end
            if (cmd.scan_next)
            begin
                scan_ch_reg <= scan_ch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.apply)
        begin
            res_reg.status <= '0;
            res_reg.error  <= apply_err;
        end
        if (cmd.tick_adv || (cmd.q_num && trivial))
        begin
            res_reg.status <= '0;
            res_reg.error  <= pccs_pkg::ERR_OK;
        end
        if (cmd.q_fin)
        begin
            res_reg.status <= (quot > pccs_pkg::DIVW'(pccs_pkg::STATUS_ONE))
                              ? pccs_pkg::STATUS_ONE : quot[16:0];
            res_reg.error  <= pccs_pkg::ERR_OK;
        end
        if (cmd.q_mul)
        begin
            diff_reg <= max_r - cnt_r;
            maxq_reg <= max_r;
            prod_reg <= PW'(pcnt_r) * PW'(coeff_reg);
        end
    end

    // Update per-channel credit and phantom queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                max_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                win_reg[i]  <= '0;
                pcnt_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.apply && ch_ok)
            begin
                case (item_reg.command)
                    pccs_pkg::CMD_INIT:
                    begin
                        max_reg[act_ch] <= item_reg.credits;
                        cnt_reg[act_ch] <= item_reg.credits;
                        win_reg[act_ch] <= item_reg.window_length;
                    end
                    pccs_pkg::CMD_RETURN:
                    begin
                        if (cnt_r < max_r)
                        begin
                            cnt_reg[act_ch] <= cnt_r + 7'd1;
                        end
                    end
                    pccs_pkg::CMD_CONSUME:
                    begin
                        if (cnt_r != 7'd0)
                        begin
                            cnt_reg[act_ch] <= cnt_r - 7'd1;
                        end
                        if (add_entry)
                        begin
                            tail_reg[act_ch] <= next_slot(tail_r);
                            pcnt_reg[act_ch] <= pcnt_r + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.retire)
            begin
                head_reg[act_ch] <= next_slot(head_r);
                pcnt_reg[act_ch] <= pcnt_r - 1'b1;
            end
        end
    end

    // Write a new expiry at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.apply && add_entry)
        begin
            mem[mem_addr(act_ch, tail_r)] <= now_reg + {4'h0, win_r};
        end
    end

    // Read the expiry at the head of the scanned channel
    always_ff @(posedge clk)
    begin
        if (cmd.rd_head)
        begin
            rd_data_reg <= mem[mem_addr(act_ch, head_r)];
        end
    end

    pccs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.q_num),
        .step     (cmd.div_step),
        .dividend ({num[14:0], 8'h00}),
        .divisor  (maxq_reg),
        .quotient (quot),
        .last     (div_last)
    );

    always_comb
    begin
        sts.command       = item_reg.command;
        sts.scan_nonempty = (pcnt_r != '0);
        sts.scan_last     = (scan_ch_reg == CHW'(NCH - 1));
        sts.head_expired  = !age[15];
        sts.q_trivial     = trivial;
        sts.div_last      = div_last;
    end

    assign result = res_reg;

endmodule

FILE: rtl/pccs_ctrl.sv
// Controller state machine that sequences each command through the datapath.
// Depends on pccs_pkg for the command and status structs.
module pccs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  pccs_pkg::pccs_sts_t sts,
    output pccs_pkg::pccs_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_T_RD,
        ST_T_CHK,
        ST_Q_MUL,
        ST_Q_NUM,
        ST_Q_DIV,
        ST_Q_FIN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.command == pccs_pkg::CMD_TICK)
                begin
                    state_next = ST_TICK;
                end
                else if (sts.command == pccs_pkg::CMD_QUERY)
                begin
                    state_next = ST_Q_MUL;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_TICK:
            begin
                cmd.tick_adv = 1'b1;
                state_next   = ST_T_RD;
            end
            ST_T_RD:
            begin
                if (sts.scan_nonempty)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_T_CHK;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_T_CHK:
            begin
                if (sts.head_expired)
                begin
                    cmd.retire = 1'b1;
                    state_next = ST_T_RD;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_T_RD;
                end
            end
            ST_Q_MUL:
            begin
                cmd.q_mul  = 1'b1;
                state_next = ST_Q_NUM;
            end
            ST_Q_NUM:
            begin
                cmd.q_num  = 1'b1;
                state_next = sts.q_trivial ? ST_EMIT : ST_Q_DIV;
            end
            ST_Q_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_Q_FIN;
                end
            end
            ST_Q_FIN:
            begin
                cmd.q_fin  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered busy and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_next == ST_EMIT);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: rtl/phantom_credit_congestion_sensor_core.sv
// Top level of the phantom credit congestion sensor.
// Depends on pccs_pkg, pccs_ctrl and pccs_datapath.
//
// One command at a time: start is taken while busy is low, and the result
// beat shows on result for the single cycle that done is high. It must be
// taken then, because there is no way to hold a result back. Init, credit
// return, credit consume and unknown commands go from the decode state
// straight to the emit state that raises done, and the next start is taken
// once the block is back in idle. A query runs a multiply, then the 23-step
// restoring divider, before done. A query whose answer is zero without
// dividing (maximum of zero, channel out of range or numerator not
// positive) skips the divider. A tick walks every channel head through
// the single read port of the expiry memory, retiring expired entries,
// before done. The phantom weight coefficient is to be written through
// cfg_we and cfg_data by the user only while the block is idle; the
// block itself has no check for it.
module phantom_credit_congestion_sensor_core #(
    parameter int PORTS         = 8,
    parameter int VCS           = 4,
    parameter int PHANTOM_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pccs_pkg::in_item_t  item,
    output logic                done,
    output pccs_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data
);

    pccs_pkg::pccs_cmd_t cmd;
    pccs_pkg::pccs_sts_t sts;

    pccs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    pccs_datapath #(
        .PORTS         (PORTS),
        .VCS           (VCS),
        .PHANTOM_DEPTH (PHANTOM_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

endmodule

FILE: rtl/pccs_checker.sv
// Port-level checks of the congestion sensor, bound to its top level.
// Depends on pccs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pccs_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input pccs_pkg::out_item_t result
);

    // A result beat belongs to a command in flight
    `ASSERT_IMP(a_done_busy, done, busy)
    // An accepted command makes the block busy
    `ASSERT_NXT(a_start_busy, start && !busy, busy)
    // One beat per command
    `ASSERT_NXT(a_done_single, done, !done)
    // An error carries a zero status
    `ASSERT_IMP(a_err_status, done && (result.error != pccs_pkg::ERR_OK), result.status == '0)
    // The fraction never exceeds one
    `ASSERT_IMP(a_status_max, done, result.status <= pccs_pkg::STATUS_ONE)

endmodule

bind phantom_credit_congestion_sensor_core pccs_checker u_chk (.*);
